// ===== rtl/core/ill_pkg.sv =====
// Shared types, codes and helpers of the indexed linked list engine.
package ill_pkg;

    localparam int unsigned MAX_IDS = 1024;
    localparam int unsigned ID_W    = 10;
    localparam int unsigned ADDR_W  = $clog2(MAX_IDS);
    localparam int unsigned ACT_W   = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_FIRST  = 3'd0,
        ACT_BEFORE = 3'd1,
        ACT_AFTER  = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_QUERY  = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ANCHOR  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic [ADDR_W-1:0] raddr;
    } link_req_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } pres_req_t;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] head;
        logic [ID_W-1:0] prev;
        logic [ID_W-1:0] next;
        logic            present;
    } result_t;

    // id 0 means none; ids at or above the table depth are never stored
    function automatic logic id_usable(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) < MAX_IDS);
    endfunction

    function automatic logic [ADDR_W-1:0] id_addr(input logic [ID_W-1:0] id);
        return ADDR_W'(id);
    endfunction

endpackage

// ===== rtl/core/indexed_linked_list_engine.sv =====
// Indexed doubly linked list engine: link RAMs, sequencer and result register.
// Keeps an ordered list of ids 1..1023 as previous/next links and a present bit per id,
// each in a synchronous RAM with a registered read, plus a head register. After reset a
// clearing pass zeroes the present bits; no word is accepted until it ends. Each word
// then passes through acceptance (reads issued), S_READ (item links and anchor presence
// read) and S_EXEC (decide and write) before its result is offered in S_DONE; a successful
// insert before or after an anchor also passes through S_LINK2, as the single write port
// of each link RAM needs a further write for the neighbour and anchor links. One word is
// in work at a time; a finished result sits in the output register so the next word can
// be accepted while it waits.
module indexed_linked_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // anchor_id[9:0], item_id[19:10], zero pad
    input  logic [2:0]  s_axis_tuser,  // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // head_id[9:0], prev_id[19:10], next_id[29:20],
                                       // is_present[30], zero pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    ill_pkg::link_req_t          next_req;
    ill_pkg::link_req_t          prev_req;
    ill_pkg::pres_req_t          pres_req;
    logic [ill_pkg::ID_W-1:0]    next_rdata;
    logic [ill_pkg::ID_W-1:0]    prev_rdata;
    logic                        pres_rdata;
    logic                        res_valid;
    logic                        res_ready;
    ill_pkg::result_t            res;

    logic                        m_valid_reg, m_valid_next;
    ill_pkg::result_t            m_res_reg, m_res_next;

    ill_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .in_anchor  (s_axis_tdata[9:0]),
        .in_item    (s_axis_tdata[19:10]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .next_req   (next_req),
        .next_rdata (next_rdata),
        .prev_req   (prev_req),
        .prev_rdata (prev_rdata),
        .pres_req   (pres_req),
        .pres_rdata (pres_rdata)
    );

    ill_ram #(
        .WIDTH (ill_pkg::ID_W),
        .DEPTH (ill_pkg::MAX_IDS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_req.we),
        .waddr (next_req.waddr),
        .wdata (next_req.wdata),
        .raddr (next_req.raddr),
        .rdata (next_rdata)
    );

    ill_ram #(
        .WIDTH (ill_pkg::ID_W),
        .DEPTH (ill_pkg::MAX_IDS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_req.we),
        .waddr (prev_req.waddr),
        .wdata (prev_req.wdata),
        .raddr (prev_req.raddr),
        .rdata (prev_rdata)
    );

    ill_ram #(
        .WIDTH (1),
        .DEPTH (ill_pkg::MAX_IDS)
    ) u_pres_ram (
        .clk   (clk),
        .we    (pres_req.we),
        .waddr (pres_req.waddr),
        .wdata (pres_req.wdata),
        .raddr (pres_req.raddr),
        .rdata (pres_rdata)
    );

    // output word register: refilled as soon as the old word leaves
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_res_reg   <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            m_res_reg   <= m_res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_res_reg.present, m_res_reg.next, m_res_reg.prev,
                            m_res_reg.head};
    assign m_axis_tuser  = m_res_reg.status;

endmodule

// ===== rtl/core/ill_ram.sv =====
// Generic single write port RAM with one registered read port.
module ill_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ill_ctrl.sv =====
// Sequencer of the list engine: reads links, decides, writes links back, holds the head.
module ill_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ill_pkg::ACT_W-1:0] in_action,
    input  logic [ill_pkg::ID_W-1:0]  in_anchor,
    input  logic [ill_pkg::ID_W-1:0]  in_item,
    output logic                      res_valid,
    input  logic                      res_ready,
    output ill_pkg::result_t          res,
    output ill_pkg::link_req_t        next_req,
    input  logic [ill_pkg::ID_W-1:0]  next_rdata,
    output ill_pkg::link_req_t        prev_req,
    input  logic [ill_pkg::ID_W-1:0]  prev_rdata,
    output ill_pkg::pres_req_t        pres_req,
    input  logic                      pres_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_LINK2,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [ill_pkg::ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [ill_pkg::ID_W-1:0]      head_reg, head_next;
    logic [ill_pkg::ACT_W-1:0]     action_reg, action_next;
    logic [ill_pkg::ID_W-1:0]      anchor_reg, anchor_next;
    logic [ill_pkg::ID_W-1:0]      item_reg, item_next;
    logic                          pres_item_reg, pres_item_next;
    logic [ill_pkg::ID_W-1:0]      a_prev_reg, a_prev_next;
    logic [ill_pkg::ID_W-1:0]      a_next_reg, a_next_next;
    ill_pkg::result_t              res_reg, res_next;

    logic accept;
    logic item_ok;
    logic item_in;
    logic anchor_in;

    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_DONE) && res_ready);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // in the execute cycle the link RAMs return the item's own links
    assign item_ok   = ill_pkg::id_usable(item_reg);
    assign item_in   = item_ok && pres_item_reg;
    assign anchor_in = ill_pkg::id_usable(anchor_reg) && pres_rdata;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        head_next      = head_reg;
        action_next    = action_reg;
        anchor_next    = anchor_reg;
        item_next      = item_reg;
        pres_item_next = pres_item_reg;
        a_prev_next    = a_prev_reg;
        a_next_next    = a_next_reg;
        res_next       = res_reg;

        next_req.we    = 1'b0;
        next_req.waddr = ill_pkg::id_addr(item_reg);
        next_req.wdata = '0;
        next_req.raddr = ill_pkg::id_addr(item_reg);
        prev_req.we    = 1'b0;
        prev_req.waddr = ill_pkg::id_addr(item_reg);
        prev_req.wdata = '0;
        prev_req.raddr = ill_pkg::id_addr(item_reg);
        pres_req.we    = 1'b0;
        pres_req.waddr = ill_pkg::id_addr(item_reg);
        pres_req.wdata = 1'b0;
        pres_req.raddr = ill_pkg::id_addr(item_reg);

        case (state_reg)
            S_CLEAR:
            begin
                pres_req.we    = 1'b1;
                pres_req.waddr = clr_cnt_reg;
                pres_req.wdata = 1'b0;
                clr_cnt_next   = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ill_pkg::ADDR_W'(ill_pkg::MAX_IDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_READ:
            begin
                // anchor links (or item links) arrive; now fetch item links and anchor presence
                pres_item_next = pres_rdata;
                a_prev_next    = prev_rdata;
                a_next_next    = next_rdata;
                next_req.raddr = ill_pkg::id_addr(item_reg);
                prev_req.raddr = ill_pkg::id_addr(item_reg);
                pres_req.raddr = ill_pkg::id_addr(anchor_reg);
                state_next     = S_EXEC;
            end
            S_EXEC:
            begin
                state_next       = S_DONE;
                res_next.status  = ill_pkg::ST_OK;
                res_next.prev    = '0;
                res_next.next    = '0;
                res_next.present = 1'b0;
                case (action_reg)
                    ill_pkg::ACT_FIRST, ill_pkg::ACT_BEFORE, ill_pkg::ACT_AFTER:
                    begin
                        if (!item_ok)
                        begin
                            res_next.status = ill_pkg::ST_ABSENT;
                        end
                        else if (pres_item_reg)
                        begin
                            res_next.status  = ill_pkg::ST_PRESENT;
                            res_next.prev    = prev_rdata;
                            res_next.next    = next_rdata;
                            res_next.present = 1'b1;
                        end
                        else if (action_reg == ill_pkg::ACT_FIRST)
                        begin
                            if (head_reg != '0)
                            begin
                                res_next.status = ill_pkg::ST_ANCHOR;
                            end
                            else
                            begin
                                prev_req.we      = 1'b1;
                                prev_req.wdata   = '0;
                                next_req.we      = 1'b1;
                                next_req.wdata   = '0;
                                pres_req.we      = 1'b1;
                                pres_req.wdata   = 1'b1;
                                head_next        = item_reg;
                                res_next.present = 1'b1;
                            end
                        end
                        else if (!anchor_in)
                        begin
                            res_next.status = ill_pkg::ST_ANCHOR;
                        end
                        else if (action_reg == ill_pkg::ACT_BEFORE)
                        begin
                            prev_req.we      = 1'b1;
                            prev_req.wdata   = a_prev_reg;
                            next_req.we      = 1'b1;
                            next_req.wdata   = anchor_reg;
                            pres_req.we      = 1'b1;
                            pres_req.wdata   = 1'b1;
                            if (head_reg == anchor_reg)
                            begin
                                head_next = item_reg;
                            end
                            res_next.prev    = a_prev_reg;
                            res_next.next    = anchor_reg;
                            res_next.present = 1'b1;
                            state_next       = S_LINK2;
                        end
                        else
                        begin
                            prev_req.we      = 1'b1;
                            prev_req.wdata   = anchor_reg;
                            next_req.we      = 1'b1;
                            next_req.wdata   = a_next_reg;
                            pres_req.we      = 1'b1;
                            pres_req.wdata   = 1'b1;
                            res_next.prev    = anchor_reg;
                            res_next.next    = a_next_reg;
                            res_next.present = 1'b1;
                            state_next       = S_LINK2;
                        end
                    end
                    ill_pkg::ACT_REMOVE:
                    begin
                        if (!item_in)
                        begin
                            res_next.status = ill_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            next_req.we    = ill_pkg::id_usable(prev_rdata);
                            next_req.waddr = ill_pkg::id_addr(prev_rdata);
                            next_req.wdata = next_rdata;
                            prev_req.we    = ill_pkg::id_usable(next_rdata);
                            prev_req.waddr = ill_pkg::id_addr(next_rdata);
                            prev_req.wdata = prev_rdata;
                            pres_req.we    = 1'b1;
                            pres_req.wdata = 1'b0;
                            if (head_reg == item_reg)
                            begin
                                head_next = next_rdata;
                            end
                        end
                    end
                    default:
                    begin
                        // query; spare action codes behave the same
                        if (item_in)
                        begin
                            res_next.prev    = prev_rdata;
                            res_next.next    = next_rdata;
                            res_next.present = 1'b1;
                        end
                        else
                        begin
                            res_next.status = ill_pkg::ST_ABSENT;
                        end
                    end
                endcase
                res_next.head = head_next;
            end
            S_LINK2:
            begin
                // neighbour and anchor links of a successful insert
                if (action_reg == ill_pkg::ACT_BEFORE)
                begin
                    next_req.we    = ill_pkg::id_usable(a_prev_reg);
                    next_req.waddr = ill_pkg::id_addr(a_prev_reg);
                    next_req.wdata = item_reg;
                    prev_req.we    = 1'b1;
                    prev_req.waddr = ill_pkg::id_addr(anchor_reg);
                    prev_req.wdata = item_reg;
                end
                else
                begin
                    prev_req.we    = ill_pkg::id_usable(a_next_reg);
                    prev_req.waddr = ill_pkg::id_addr(a_next_reg);
                    prev_req.wdata = item_reg;
                    next_req.we    = 1'b1;
                    next_req.waddr = ill_pkg::id_addr(anchor_reg);
                    next_req.wdata = item_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            action_next    = in_action;
            anchor_next    = in_anchor;
            item_next      = in_item;
            pres_req.raddr = ill_pkg::id_addr(in_item);
            if ((in_action == ill_pkg::ACT_BEFORE) || (in_action == ill_pkg::ACT_AFTER))
            begin
                next_req.raddr = ill_pkg::id_addr(in_anchor);
                prev_req.raddr = ill_pkg::id_addr(in_anchor);
            end
            else
            begin
                next_req.raddr = ill_pkg::id_addr(in_item);
                prev_req.raddr = ill_pkg::id_addr(in_item);
            end
            state_next = S_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            action_reg    <= '0;
            anchor_reg    <= '0;
            item_reg      <= '0;
            pres_item_reg <= 1'b0;
            a_prev_reg    <= '0;
            a_next_reg    <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            action_reg    <= action_next;
            anchor_reg    <= anchor_next;
            item_reg      <= item_next;
            pres_item_reg <= pres_item_next;
            a_prev_reg    <= a_prev_next;
            a_next_reg    <= a_next_next;
            res_reg       <= res_next;
        end
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ))
        else $error("accepted word did not start the link read");

    a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && (res_next.status == ill_pkg::ST_OK) &&
         ((action_reg == ill_pkg::ACT_FIRST) || (action_reg == ill_pkg::ACT_BEFORE) ||
          (action_reg == ill_pkg::ACT_AFTER))) |=> (head_reg != '0))
        else $error("successful insert left the list without a head");

    a_link2_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LINK2) && next_req.we) |-> (next_req.waddr != '0))
        else $error("neighbour link written at the none id");

    a_pres_item: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && pres_req.we) |->
            (pres_req.waddr == ill_pkg::id_addr(item_reg)))
        else $error("presence written away from the item id");

    a_res_present: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.present) |->
            ((res_reg.status == ill_pkg::ST_OK) || (res_reg.status == ill_pkg::ST_PRESENT)))
        else $error("present item reported with a failing status");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the indexed linked list engine.
module tb;
    import ill_pkg::*;

    localparam logic [ID_W-1:0] NO_ID = '0;
    // action codes with no meaning of their own; the block treats them as a query
    localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_C = 3'd7;
    localparam int STALL_LIMIT = 5000;  // covers the clearing pass after reset
    localparam int TAIL_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // anchor_id[9:0], item_id[19:10], zero pad
    logic [2:0]  s_axis_tuser = '0;  // action[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // head_id[9:0], prev_id[19:10], next_id[29:20],
                                     // is_present[30], zero pad
    logic [1:0]  m_axis_tuser;       // status[1:0]

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures = 0;
    int quiet_cycles = 0;

    // shadow of the list: links, membership, head and length
    logic [ID_W-1:0] nxt_of [MAX_IDS];
    logic [ID_W-1:0] prv_of [MAX_IDS];
    bit              in_list [MAX_IDS];
    logic [ID_W-1:0] list_head = '0;
    int              list_len = 0;

    result_t expected_q [$];

    indexed_linked_list_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit id_ok(input logic [ID_W-1:0] id);
        return (id != NO_ID) && (int'(id) < MAX_IDS);
    endfunction

    function automatic bit listed(input logic [ID_W-1:0] id);
        return id_ok(id) && in_list[id];
    endfunction

    // applies one word to the shadow list and returns the result it must give
    function automatic result_t apply_word(input logic [ACT_W-1:0] act,
                                           input logic [ID_W-1:0] anc,
                                           input logic [ID_W-1:0] itm);
        result_t         res;
        logic [ID_W-1:0] nb;
        logic [ID_W-1:0] pv;
        res.status = ST_OK;
        if (act == ACT_FIRST || act == ACT_BEFORE || act == ACT_AFTER)
        begin
            if (!id_ok(itm))
                res.status = ST_ABSENT;
            else if (in_list[itm])
                res.status = ST_PRESENT;
            else if (act == ACT_FIRST)
            begin
                if (list_head != NO_ID)
                    res.status = ST_ANCHOR;
                else
                begin
                    prv_of[itm] = NO_ID;
                    nxt_of[itm] = NO_ID;
                    in_list[itm] = 1'b1;
                    list_head = itm;
                    list_len++;
                end
            end
            else if (!listed(anc))
                res.status = ST_ANCHOR;
            else if (act == ACT_BEFORE)
            begin
                nb = prv_of[anc];
                prv_of[itm] = nb;
                nxt_of[itm] = anc;
                if (id_ok(nb))
                    nxt_of[nb] = itm;
                prv_of[anc] = itm;
                if (list_head == anc)
                    list_head = itm;
                in_list[itm] = 1'b1;
                list_len++;
            end
            else
            begin
                nb = nxt_of[anc];
                prv_of[itm] = anc;
                nxt_of[itm] = nb;
                if (id_ok(nb))
                    prv_of[nb] = itm;
                nxt_of[anc] = itm;
                in_list[itm] = 1'b1;
                list_len++;
            end
        end
        else if (act == ACT_REMOVE)
        begin
            if (!listed(itm))
                res.status = ST_ABSENT;
            else
            begin
                pv = prv_of[itm];
                nb = nxt_of[itm];
                if (id_ok(pv))
                    nxt_of[pv] = nb;
                if (id_ok(nb))
                    prv_of[nb] = pv;
                if (list_head == itm)
                    list_head = nb;
                in_list[itm] = 1'b0;
                list_len--;
            end
        end
        else if (!listed(itm))
            res.status = ST_ABSENT;
        res.head = list_head;
        if (listed(itm))
        begin
            res.prev = prv_of[itm];
            res.next = nxt_of[itm];
            res.present = 1'b1;
        end
        else
        begin
            res.prev = NO_ID;
            res.next = NO_ID;
            res.present = 1'b0;
        end
        return res;
    endfunction

    // random id somewhere in the list; list must not be empty
    function automatic logic [ID_W-1:0] pick_member();
        logic [ID_W-1:0] id;
        int              steps;
        id = list_head;
        steps = $urandom_range(0, list_len - 1);
        repeat (steps) id = nxt_of[id];
        return id;
    endfunction

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result check first, then prediction of any word taken on the same edge
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.status  = status_t'(m_axis_tuser);
            got.head    = m_axis_tdata[9:0];
            got.prev    = m_axis_tdata[19:10];
            got.next    = m_axis_tdata[29:20];
            got.present = m_axis_tdata[30];
            if (expected_q.size() == 0)
            begin
                $error("result with no word pending: tdata %h tuser %0d",
                       m_axis_tdata, m_axis_tuser);
                failures++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.head !== want.head)
                begin
                    $error("head_id: expected %0d, got %0d", want.head, got.head);
                    failures++;
                end
                if (got.prev !== want.prev)
                begin
                    $error("prev_id: expected %0d, got %0d", want.prev, got.prev);
                    failures++;
                end
                if (got.next !== want.next)
                begin
                    $error("next_id: expected %0d, got %0d", want.next, got.next);
                    failures++;
                end
                if (got.present !== want.present)
                begin
                    $error("is_present: expected %0d, got %0d", want.present, got.present);
                    failures++;
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready)
            expected_q.push_back(apply_word(s_axis_tuser, s_axis_tdata[9:0],
                                            s_axis_tdata[19:10]));
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] anc,
                             input logic [ID_W-1:0] itm);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, itm, anc};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (expected_q.size() != 0);
    endtask

    task automatic test_empty_list();
        send_word(ACT_QUERY, NO_ID, 10'd5);
        send_word(ACT_REMOVE, NO_ID, 10'd5);
        send_word(ACT_BEFORE, 10'd7, 10'd5);    // no anchor in an empty list
        send_word(ACT_FIRST, NO_ID, NO_ID);     // id none is unusable
        send_word(ACT_FIRST, NO_ID, 10'd512);
        send_word(ACT_FIRST, NO_ID, 10'd3);     // list no longer empty
        send_word(ACT_FIRST, NO_ID, 10'd512);   // already in the list
    endtask

    task automatic test_neighbours();
        send_word(ACT_AFTER, 10'd512, 10'd1023);
        send_word(ACT_BEFORE, 10'd512, 10'd1);  // new head
        send_word(ACT_AFTER, 10'd1, 10'd700);
        send_word(ACT_BEFORE, 10'd1023, 10'd2);
        send_word(ACT_AFTER, 10'd700, 10'd700); // anchor is the item, item present
        send_word(ACT_BEFORE, 10'd9, 10'd9);    // anchor is the item, item absent
        send_word(ACT_AFTER, NO_ID, 10'd4);     // anchor none
        send_word(ACT_QUERY, NO_ID, 10'd700);
        send_word(ACT_RSVD_A, 10'd1023, 10'd1023);
        send_word(ACT_RSVD_B, NO_ID, NO_ID);
        send_word(ACT_RSVD_C, 10'd1, 10'd2);
    endtask

    task automatic test_removal();
        send_word(ACT_REMOVE, NO_ID, 10'd1);    // head moves on
        send_word(ACT_REMOVE, NO_ID, 10'd1023); // tail
        send_word(ACT_REMOVE, NO_ID, 10'd512);  // middle
        send_word(ACT_REMOVE, NO_ID, NO_ID);
        send_word(ACT_REMOVE, NO_ID, 10'd700);
        send_word(ACT_REMOVE, NO_ID, 10'd2);    // list now empty
        send_word(ACT_FIRST, NO_ID, 10'd9);
    endtask

    task automatic test_random(input int words, input int send_pct, input int recv_pct);
        int              r;
        int              grow;
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0] anc;
        logic [ID_W-1:0] itm;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < words; k++)
        begin
            if (k == words / 2)
                wait_all_results();
            r    = $urandom_range(0, 99);
            grow = (list_len < 24) ? 65 : ((list_len > 48) ? 40 : 52);
            act  = ACT_QUERY;
            anc  = 10'($urandom_range(0, 1023));
            itm  = 10'($urandom_range(1, 1023));
            if (r < 6)
            begin
                act = 3'($urandom_range(0, 7));
                itm = 10'($urandom_range(0, 1023));
            end
            else if (list_len == 0)
                act = ACT_FIRST;
            else if (r < 12)
            begin
                act = $urandom_range(0, 1) ? ACT_BEFORE : ACT_AFTER;
                anc = pick_member();
                itm = pick_member();
            end
            else if (r < 16)
                act = ACT_FIRST;
            else if (r < 20)
                act = ACT_REMOVE;
            else if (r < grow)
            begin
                act = $urandom_range(0, 1) ? ACT_BEFORE : ACT_AFTER;
                anc = pick_member();
            end
            else if (r < grow + 20)
            begin
                act = ACT_REMOVE;
                itm = pick_member();
            end
            else
            begin
                act = ($urandom_range(0, 9) == 0) ?
                      3'($urandom_range(ACT_RSVD_A, ACT_RSVD_C)) : ACT_QUERY;
                itm = pick_member();
            end
            send_word(act, anc, itm);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 47;
        test_empty_list();
        test_neighbours();
        test_removal();
        test_random(250, 14, 47);
        test_random(250, 47, 14);
        test_random(250, 0, 0);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ill_pkg.sv
rtl/core/ill_ram.sv
rtl/core/ill_ctrl.sv
rtl/core/indexed_linked_list_engine.sv
tb/sv/tb.sv
